FILE: rtl/core/single_wire_led_frame_serializer_assert.svh
// Assertion macros for the single-wire LED frame serializer.
// Used by rtl/core/single_wire_led_frame_serializer.sv; needs clk_i and rst_ni in scope.
`ifndef SINGLE_WIRE_LED_FRAME_SERIALIZER_ASSERT_SVH
`define SINGLE_WIRE_LED_FRAME_SERIALIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk_i, skipped while reset is asserted.
`define SWLED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("swled assertion failed");

// Checked at every rising edge of clk_i, also during reset.
`define SWLED_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("swled assertion failed");

`else

`define SWLED_ASSERT(lbl, prop)
`define SWLED_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: rtl/core/swled_pkg.sv
// Shared types and constants for the single-wire LED frame serializer.
// No dependencies; imported by rtl/core/single_wire_led_frame_serializer.sv.
package swled_pkg;

  localparam int unsigned TickW   = 8;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned BitPosW = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [BitPosW-1:0] LastBit = 5'd31;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FRAME_COMMAND    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_HIGH_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_LOW_TICKS  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DATA_TICKS       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TAIL_LOW_TICKS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_END_GAP_TICKS    = 3'd5;

  // Register values after reset.
  localparam logic [7:0]       RstFrameCommand = 8'h3A;
  localparam logic [TickW-1:0] RstStartHigh    = 8'd2;
  localparam logic [TickW-1:0] RstStartLow     = 8'd3;
  localparam logic [TickW-1:0] RstData         = 8'd10;
  localparam logic [TickW-1:0] RstTailLow      = 8'd5;
  localparam logic [TickW-1:0] RstEndGap       = 8'd80;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HIGH = 3'd1,
    PH_LOW  = 3'd2,
    PH_DATA = 3'd3,
    PH_TAIL = 3'd4,
    PH_GAP  = 3'd5
  } phase_e;

  // A programmed tick count of zero behaves as one tick.
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] ticks);
    at_least_one = (ticks == '0) ? {{(TickW-1){1'b0}}, 1'b1} : ticks;
  endfunction

endpackage

FILE: rtl/core/single_wire_led_frame_serializer.sv
// Single-wire LED frame serializer: tick-driven phase sequencer with a result register.
// Depends on swled_pkg and single_wire_led_frame_serializer_assert.svh.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o    | command_i, red_i, green_i, blue_i
//   out     | output    | out_valid_o / out_stall_i  | line_level_o, busy_res_o,
//           |           |                            | frame_done_o, request_dropped_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each input word is one line tick; its result word is registered in the output register
// on acceptance, so one word per cycle is sustained while the output is not stalled.
// Reset loads the default register values and puts the sequencer in idle.
// A new word is taken while a result waits only if that result is taken in the same cycle.
// Configuration writes are always accepted; indexes above five are ignored.

`include "single_wire_led_frame_serializer_assert.svh"

module single_wire_led_frame_serializer
  import swled_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               line_level_o,
  output logic               busy_res_o,
  output logic               frame_done_o,
  output logic               request_dropped_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0]       frame_command_q;
  logic [TickW-1:0] start_high_q, start_low_q, data_ticks_q, tail_low_q, end_gap_q;

  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   ticks_q, ticks_d;
  logic [BitPosW-1:0] bit_pos_q, bit_pos_d;
  logic [FrameW-1:0]  frame_q, frame_d;

  logic out_valid_q;
  logic level_q, busy_q, done_q, dropped_q;
  logic level_d, busy_d, done_d, dropped_d;

  logic               in_fire;
  logic               is_idle;
  logic               start;
  phase_e             cur_phase;
  logic [TickW-1:0]   cur_ticks;
  logic [BitPosW-1:0] cur_bit_pos;
  logic [FrameW-1:0]  cur_frame;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_command_q <= RstFrameCommand;
      start_high_q    <= RstStartHigh;
      start_low_q     <= RstStartLow;
      data_ticks_q    <= RstData;
      tail_low_q      <= RstTailLow;
      end_gap_q       <= RstEndGap;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_COMMAND:    frame_command_q <= cfg_data_i;
        CFG_START_HIGH_TICKS: start_high_q    <= cfg_data_i;
        CFG_START_LOW_TICKS:  start_low_q     <= cfg_data_i;
        CFG_DATA_TICKS:       data_ticks_q    <= cfg_data_i;
        CFG_TAIL_LOW_TICKS:   tail_low_q      <= cfg_data_i;
        CFG_END_GAP_TICKS:    end_gap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The output register frees up in the same cycle its word is taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // A request taken in idle makes this tick the first tick of the first high phase.
  assign is_idle     = (phase_q == PH_IDLE);
  assign start       = is_idle && command_i;
  assign cur_phase   = start ? PH_HIGH : phase_q;
  assign cur_ticks   = start ? at_least_one(start_high_q) : ticks_q;
  assign cur_bit_pos = start ? '0 : bit_pos_q;
  assign cur_frame   = start ? {frame_command_q, red_i, blue_i, green_i} : frame_q;

  // Next state. The frame shifts left after each bit, so its top bit is the data bit.
  always_comb begin
    phase_d   = cur_phase;
    ticks_d   = cur_ticks;
    bit_pos_d = cur_bit_pos;
    frame_d   = cur_frame;
    if (cur_ticks > {{(TickW-1){1'b0}}, 1'b1}) begin
      ticks_d = cur_ticks - {{(TickW-1){1'b0}}, 1'b1};
    end else begin
      case (cur_phase)
        PH_HIGH: begin
          phase_d = PH_LOW;
          ticks_d = at_least_one(start_low_q);
        end
        PH_LOW: begin
          phase_d = PH_DATA;
          ticks_d = at_least_one(data_ticks_q);
        end
        PH_DATA: begin
          phase_d = PH_TAIL;
          ticks_d = at_least_one(tail_low_q);
        end
        PH_TAIL: begin
          if (cur_bit_pos == LastBit) begin
            phase_d = PH_GAP;
            ticks_d = at_least_one(end_gap_q);
          end else begin
            phase_d   = PH_HIGH;
            ticks_d   = at_least_one(start_high_q);
            bit_pos_d = cur_bit_pos + {{(BitPosW-1){1'b0}}, 1'b1};
            frame_d   = {cur_frame[FrameW-2:0], 1'b0};
          end
        end
        default: begin
          phase_d = PH_IDLE;
          ticks_d = '0;
        end
      endcase
    end
  end

  // Result word of this tick.
  always_comb begin
    level_d   = 1'b0;
    busy_d    = !(is_idle && !command_i);
    done_d    = 1'b0;
    dropped_d = !is_idle && command_i;
    case (cur_phase)
      PH_HIGH: level_d = 1'b1;
      PH_DATA: level_d = cur_frame[FrameW-1];
      PH_GAP:  done_d  = (cur_ticks <= {{(TickW-1){1'b0}}, 1'b1});
      default: level_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      bit_pos_q   <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q   <= phase_d;
        ticks_q   <= ticks_d;
        bit_pos_q <= bit_pos_d;
        frame_q   <= frame_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      level_q   <= level_d;
      busy_q    <= busy_d;
      done_q    <= done_d;
      dropped_q <= dropped_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign line_level_o      = level_q;
  assign busy_res_o        = busy_q;
  assign frame_done_o      = done_q;
  assign request_dropped_o = dropped_q;

  `SWLED_ASSERT_ALWAYS(a_idle_no_ticks, (rst_ni && phase_q == PH_IDLE) |-> (ticks_q == '0))
  `SWLED_ASSERT(a_busy_has_ticks, (phase_q != PH_IDLE) |-> (ticks_q != '0))
  `SWLED_ASSERT(a_done_returns_idle, (in_fire && done_d) |=> (phase_q == PH_IDLE))
  `SWLED_ASSERT(a_request_starts, (in_fire && is_idle && command_i) |=> (phase_q != PH_IDLE))
  `SWLED_ASSERT(a_empty_never_stalls, !out_valid_q |-> !in_stall_o)

endmodule
